>>> src/lbb_pkg.sv
// Shared request types and operation codes for the label bounding box table.
`timescale 1ns / 1ps

package lbb_pkg;

    localparam int LABEL_W = 8;
    localparam int FIELD_W = 12;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic               operation;
        logic [FIELD_W-1:0] pixel_x;
        logic [FIELD_W-1:0] pixel_y;
        logic [LABEL_W-1:0] label_id;
    } t_in_req;

    typedef struct packed {
        logic [LABEL_W-1:0] read_label;
        logic               was_seen;
        logic [FIELD_W-1:0] left_x;
        logic [FIELD_W-1:0] lower_y;
        logic [FIELD_W-1:0] right_x;
        logic [FIELD_W-1:0] upper_y;
    } t_out_req;

endpackage

>>> src/label_bounding_box_table.sv
// Top level of the per-label bounding box table: entry memory, update stage and result register.
`timescale 1ns / 1ps

//  Channel   Direction  Signals                                  Moves
//  -------   ---------  ---------------------------------------  -----------------------------
//  in        input      i_in_valid, o_in_stall, i_in_req         add-pixel or read-label request
//  out       output     o_out_valid, i_out_stall, o_out_req      box report, one per read
//
//  One request is taken per cycle while o_in_stall is low. Each request reads its label's entry from
//  the entry memory, updates it in the next cycle and writes it back; a write to the entry that the
//  following request has just read is forwarded, so back-to-back pixels of one label are exact.
//  A read request waits in the update stage while the result register is full and stalled.
//  Reset is synchronous and active low. After reset a clearing pass writes every entry of the
//  memory, one per cycle, and no request is taken until the pass is done.

module label_bounding_box_table import lbb_pkg::*; #(
    parameter int NUM_LABELS = 256,
    parameter int COORD_BITS = 12
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_req  i_in_req,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_req o_out_req
);

    // Stored coordinates only need COORD_BITS bits, but never more than the port field.
    localparam int SW = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
    // Entry layout: seen flag on top, then least x, greatest y, greatest x, least y.
    localparam int EW = 1 + 4 * SW;
    localparam int AW = (NUM_LABELS > 1) ? $clog2(NUM_LABELS) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_LABELS - 1);

    // Clearing pass state.
    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;

    // Update stage: the request whose entry is arriving from memory this cycle.
    logic               r_s1_valid;
    logic               r_s1_op;
    logic               r_s1_ok;
    logic [AW-1:0]      r_s1_addr;
    logic [LABEL_W-1:0] r_s1_label;
    logic [SW-1:0]      r_s1_x;
    logic [SW-1:0]      r_s1_y;

    // Copy of the most recent write, used when the memory read raced with it.
    logic          r_fwd_valid;
    logic [AW-1:0] r_fwd_addr;
    logic [EW-1:0] r_fwd_data;

    // Result register.
    logic     r_out_valid;
    t_out_req r_out;

    logic          in_accept;
    logic          in_ok;
    logic [AW-1:0] in_addr;
    logic [EW-1:0] rd_data;

    logic          fwd_hit;
    logic [EW-1:0] cur;
    logic          cur_seen;
    logic [SW-1:0] cur_min_x;
    logic [SW-1:0] cur_max_y;
    logic [SW-1:0] cur_max_x;
    logic [SW-1:0] cur_min_y;
    logic [SW-1:0] upd_min_x;
    logic [SW-1:0] upd_max_y;
    logic [SW-1:0] upd_max_x;
    logic [SW-1:0] upd_min_y;
    logic [EW-1:0] add_entry;

    logic          s1_add;
    logic          s1_rd;
    logic          s1_done;
    logic          s1_we;
    logic          hit;
    t_out_req      result;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [EW-1:0] mem_wdata;

    // ------------------------------------------------------------------
    // Input side. Labels beyond the table never write the memory.
    // ------------------------------------------------------------------
    assign in_ok     = ({24'd0, i_in_req.label_id} < 32'(NUM_LABELS));
    assign in_addr   = AW'(i_in_req.label_id);
    assign in_accept = i_in_valid && !o_in_stall;

    // ------------------------------------------------------------------
    // Update stage. The entry comes from memory, or from the write made at the same edge
    // as its read, which the memory does not yet show.
    // ------------------------------------------------------------------
    assign fwd_hit   = r_fwd_valid && (r_fwd_addr == r_s1_addr);
    assign cur       = fwd_hit ? r_fwd_data : rd_data;
    assign cur_seen  = cur[EW-1];
    assign cur_min_x = cur[4*SW-1:3*SW];
    assign cur_max_y = cur[3*SW-1:2*SW];
    assign cur_max_x = cur[2*SW-1:SW];
    assign cur_min_y = cur[SW-1:0];

    assign upd_min_x = (r_s1_x < cur_min_x) ? r_s1_x : cur_min_x;
    assign upd_max_y = (r_s1_y > cur_max_y) ? r_s1_y : cur_max_y;
    assign upd_max_x = (r_s1_x > cur_max_x) ? r_s1_x : cur_max_x;
    assign upd_min_y = (r_s1_y < cur_min_y) ? r_s1_y : cur_min_y;

    // The first pixel of a label opens its box on that pixel alone.
    assign add_entry = cur_seen ? {1'b1, upd_min_x, upd_max_y, upd_max_x, upd_min_y}
                                : {1'b1, r_s1_x, r_s1_y, r_s1_x, r_s1_y};

    assign s1_add  = (r_s1_op == OP_ADD);
    assign s1_rd   = (r_s1_op == OP_READ);
    // A pixel always completes; a read completes once the result register can take it.
    assign s1_done = r_s1_valid && (s1_add || !r_out_valid || !i_out_stall);
    // Background pixels change nothing; a read clears the entry it reports.
    assign s1_we   = s1_done && r_s1_ok && (s1_rd || (r_s1_label != '0));

    // An unseen label, background and labels beyond the table all report an empty box.
    assign hit = r_s1_ok && cur_seen;
    always_comb begin
        result.read_label = r_s1_label;
        result.was_seen   = hit;
        result.left_x     = hit ? FIELD_W'(cur_min_x) : '0;
        result.lower_y    = hit ? FIELD_W'(cur_max_y) : '0;
        result.right_x    = hit ? FIELD_W'(cur_max_x) : '0;
        result.upper_y    = hit ? FIELD_W'(cur_min_y) : '0;
    end

    // ------------------------------------------------------------------
    // Entry memory. The clearing pass and read-and-clear both write an all-zero entry.
    // ------------------------------------------------------------------
    assign mem_we    = r_clearing || s1_we;
    assign mem_waddr = r_clearing ? r_clr_addr : r_s1_addr;
    assign mem_wdata = (r_clearing || s1_rd) ? '0 : add_entry;

    lbb_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_LABELS)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (in_accept),
        .i_raddr (in_addr),
        .o_rdata (rd_data)
    );

    // New requests wait during the clearing pass and while a read is held in the update stage.
    assign o_in_stall = r_clearing || (r_s1_valid && !s1_done);

    // ------------------------------------------------------------------
    // Control registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == LAST_ADDR) begin
                    r_clearing <= 1'b0;
                end
            end

            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_done) begin
                r_s1_valid <= 1'b0;
            end

            if (mem_we) begin
                r_fwd_valid <= 1'b1;
            end

            if (s1_done && s1_rd) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_op    <= i_in_req.operation;
            r_s1_ok    <= in_ok;
            r_s1_addr  <= in_addr;
            r_s1_label <= i_in_req.label_id;
            r_s1_x     <= SW'(i_in_req.pixel_x);
            r_s1_y     <= SW'(i_in_req.pixel_y);
        end
        if (mem_we) begin
            r_fwd_addr <= mem_waddr;
            r_fwd_data <= mem_wdata;
        end
        if (s1_done && s1_rd) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_no_accept_while_clearing : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !in_accept)
        else $error("request accepted during the clearing pass");

    a_clear_pass_complete : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_clearing) |-> ($past(r_clr_addr) == LAST_ADDR))
        else $error("clearing pass ended before the last entry");

    a_add_entry_ordered : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_we && s1_add) |-> (mem_wdata[EW-1] &&
                               (mem_wdata[4*SW-1:3*SW] <= mem_wdata[2*SW-1:SW]) &&
                               (mem_wdata[SW-1:0] <= mem_wdata[3*SW-1:2*SW])))
        else $error("pixel update wrote an unordered box");

    a_add_gives_no_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && s1_add && !r_out_valid) |=> !r_out_valid)
        else $error("pixel request produced a result");

    a_report_ordered : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.was_seen) |-> ((r_out.left_x <= r_out.right_x) &&
                                             (r_out.upper_y <= r_out.lower_y)))
        else $error("reported box is unordered");

endmodule

>>> src/lbb_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module lbb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the per-label bounding box table.
`timescale 1ns / 1ps

module testbench;
    import lbb_pkg::*;

    localparam int NUM_ENTRIES    = 1 << LABEL_W;
    localparam int COORD_MAX      = (1 << FIELD_W) - 1;
    localparam int RESET_CYCLES   = 12;
    // The watchdog limit covers both the clearing pass after reset and the long
    // receiver hold-off below, with room to spare.
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int PHASE_ITEMS    = 410;
    localparam int MAX_REPORTS    = 100;

    // Keeps its own copy of the box table and the reports that reads are owed.
    class box_table_model;
        bit                 seen_flag [NUM_ENTRIES];
        logic [FIELD_W-1:0] least_x   [NUM_ENTRIES];
        logic [FIELD_W-1:0] most_y    [NUM_ENTRIES];
        logic [FIELD_W-1:0] most_x    [NUM_ENTRIES];
        logic [FIELD_W-1:0] least_y   [NUM_ENTRIES];
        t_out_req           pending_reports [$];
        int                 mismatch_count;

        function void apply_request(t_in_req req);
            int       lab;
            t_out_req rep;
            lab = int'(req.label_id);
            if (req.operation == OP_ADD) begin
                // Background pixels leave the table alone.
                if (lab == 0) return;
                if (!seen_flag[lab]) begin
                    seen_flag[lab] = 1'b1;
                    least_x[lab]   = req.pixel_x;
                    most_x[lab]    = req.pixel_x;
                    least_y[lab]   = req.pixel_y;
                    most_y[lab]    = req.pixel_y;
                end else begin
                    if (req.pixel_x < least_x[lab]) least_x[lab] = req.pixel_x;
                    if (req.pixel_x > most_x[lab])  most_x[lab]  = req.pixel_x;
                    if (req.pixel_y < least_y[lab]) least_y[lab] = req.pixel_y;
                    if (req.pixel_y > most_y[lab])  most_y[lab]  = req.pixel_y;
                end
            end else begin
                // An unseen label reports a zero box; a seen one is cleared by the read.
                rep            = '0;
                rep.read_label = req.label_id;
                if (seen_flag[lab]) begin
                    rep.was_seen   = 1'b1;
                    rep.left_x     = least_x[lab];
                    rep.lower_y    = most_y[lab];
                    rep.right_x    = most_x[lab];
                    rep.upper_y    = least_y[lab];
                    seen_flag[lab] = 1'b0;
                end
                pending_reports = {pending_reports, rep};
            end
        endfunction

        function bit field_differs(string name, int unsigned want, int unsigned got);
            if (want == got) return 1'b0;
            if (mismatch_count < MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            return 1'b1;
        endfunction

        function void compare_report(t_out_req got);
            t_out_req want;
            bit       bad;
            if (pending_reports.size() == 0) begin
                if (mismatch_count < MAX_REPORTS)
                    $display("%0t: unexpected report, expected none, actual %p", $time, got);
                mismatch_count++;
                return;
            end
            want = pending_reports.pop_front();
            bad  = field_differs("read_label", 32'(want.read_label), 32'(got.read_label));
            bad |= field_differs("was_seen", 32'(want.was_seen), 32'(got.was_seen));
            bad |= field_differs("left_x", 32'(want.left_x), 32'(got.left_x));
            bad |= field_differs("lower_y", 32'(want.lower_y), 32'(got.lower_y));
            bad |= field_differs("right_x", 32'(want.right_x), 32'(got.right_x));
            bad |= field_differs("upper_y", 32'(want.upper_y), 32'(got.upper_y));
            if (bad) mismatch_count++;
        endfunction
    endclass

    logic     i_clk;
    logic     i_rst_n;
    logic     i_in_valid;
    logic     o_in_stall;
    t_in_req  i_in_req;
    logic     o_out_valid;
    logic     i_out_stall;
    t_out_req o_out_req;

    box_table_model box_model;

    // Idle rates of the two sides, changed by the main sequence from phase to phase.
    int send_idle_pct;
    int stall_pct;
    int sent_count;
    int idle_cycles;
    int hold_left;
    bit hold_request;

    label_bounding_box_table i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_req   (o_out_req)
    );

    always #6 i_clk = ~i_clk;

    // Receiver: random stalls at the current rate, or a long hold-off when one is
    // asked for. The hold-off is counted here so that the sender can keep offering
    // requests meanwhile and the block backs up into its input.
    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Monitor and watchdog. Everything is sampled at the rising edge, before any of
    // the nonblocking updates of that edge land, so both sides see settled values.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                box_model.apply_request(i_in_req);
            if (o_out_valid && !i_out_stall)
                box_model.compare_report(o_out_req);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    function automatic t_in_req make_req(logic op, int x, int y, int lab);
        t_in_req req;
        req.operation = op;
        req.pixel_x   = FIELD_W'(x);
        req.pixel_y   = FIELD_W'(y);
        req.label_id  = LABEL_W'(lab);
        return req;
    endfunction

    // A coordinate near a centre, clamped to the field, or anywhere when the spread
    // covers the whole range.
    function automatic int near_coord(int centre, int spread);
        int v;
        if (spread > COORD_MAX) return int'($urandom_range(0, COORD_MAX));
        v = centre + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > COORD_MAX) v = COORD_MAX;
        return v;
    endfunction

    // Called at a rising edge; returns at the edge where the request was taken.
    // Each loop pass assigns the valid exactly once per time step.
    task automatic send_request(input t_in_req req);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= req;
        do @(posedge i_clk); while (o_in_stall);
        if (!(req.operation == OP_ADD && req.label_id == '0)) sent_count++;
    endtask

    task automatic wait_reports_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (box_model.pending_reports.size() != 0) @(posedge i_clk);
    endtask

    // Mostly whole boxes: a run of pixels of one label, usually followed by its read.
    // The rest is stray reads and lone pixels, background among them.
    task automatic run_random_traffic(input int n_items);
        int stop_at;
        int kind;
        int lab;
        int n_pix;
        int cx;
        int cy;
        int spread;
        stop_at = sent_count + n_items;
        while (sent_count < stop_at) begin
            kind = int'($urandom_range(99));
            if (kind < 75) begin
                // A few busy labels make boxes build up over several runs.
                lab    = ($urandom_range(3) == 0) ? int'($urandom_range(1, 7))
                                                  : int'($urandom_range(1, NUM_ENTRIES - 1));
                n_pix  = int'($urandom_range(1, 8));
                cx     = int'($urandom_range(0, COORD_MAX));
                cy     = int'($urandom_range(0, COORD_MAX));
                spread = ($urandom_range(3) == 0) ? COORD_MAX + 1 : int'($urandom_range(1, 64));
                repeat (n_pix)
                    send_request(make_req(OP_ADD, near_coord(cx, spread),
                                          near_coord(cy, spread), lab));
                if ($urandom_range(4) != 0)
                    send_request(make_req(OP_READ, int'($urandom_range(0, COORD_MAX)),
                                          int'($urandom_range(0, COORD_MAX)), lab));
            end else if (kind < 88) begin
                send_request(make_req(OP_READ, int'($urandom_range(0, COORD_MAX)),
                                      int'($urandom_range(0, COORD_MAX)),
                                      int'($urandom_range(0, NUM_ENTRIES - 1))));
            end else begin
                lab = ($urandom_range(3) == 0) ? 0 : int'($urandom_range(0, NUM_ENTRIES - 1));
                send_request(make_req(OP_ADD, int'($urandom_range(0, COORD_MAX)),
                                      int'($urandom_range(0, COORD_MAX)), lab));
            end
        end
    endtask

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_req      = '0;
        i_out_stall   = 1'b0;
        send_idle_pct = 0;
        stall_pct     = 0;
        sent_count    = 0;
        idle_cycles   = 0;
        hold_left     = 0;
        hold_request  = 1'b0;
        box_model     = new();

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed opening. Reads of labels never touched, label 0 included, must
        // report nothing seen and a zero box.
        send_request(make_req(OP_READ, 0, 0, 0));
        send_request(make_req(OP_READ, COORD_MAX, COORD_MAX, NUM_ENTRIES - 1));
        // A background pixel is ignored, so label 0 still reads as unseen.
        send_request(make_req(OP_ADD, COORD_MAX, COORD_MAX, 0));
        send_request(make_req(OP_READ, 0, 0, 0));
        // Opposite corners of the frame on the highest label.
        send_request(make_req(OP_ADD, 0, 0, NUM_ENTRIES - 1));
        send_request(make_req(OP_ADD, COORD_MAX, COORD_MAX, NUM_ENTRIES - 1));
        send_request(make_req(OP_READ, 0, 0, NUM_ENTRIES - 1));
        // A single pixel sets all four bounds; a second read finds the entry cleared.
        send_request(make_req(OP_ADD, COORD_MAX, 0, 1));
        send_request(make_req(OP_READ, 0, 0, 1));
        send_request(make_req(OP_READ, 0, 0, 1));
        // Back-to-back pixels of one label: the second widens least x and greatest y, the third greatest x and least y.
        send_request(make_req(OP_ADD, 100, 200, 128));
        send_request(make_req(OP_ADD, 50, 300, 128));
        send_request(make_req(OP_ADD, 150, 100, 128));
        send_request(make_req(OP_ADD, 120, 150, 128));
        send_request(make_req(OP_READ, 0, 0, 128));
        // Read squeezed between pixels of the same label: the later pixel starts afresh.
        send_request(make_req(OP_ADD, 10, 10, 7));
        send_request(make_req(OP_READ, COORD_MAX, COORD_MAX, 7));
        send_request(make_req(OP_ADD, 20, 30, 7));
        send_request(make_req(OP_READ, 0, 0, 7));
        // Interleaved labels must not disturb one another.
        send_request(make_req(OP_ADD, 2730, 1365, 85));
        send_request(make_req(OP_ADD, 1365, 2730, 170));
        send_request(make_req(OP_ADD, 4000, 5, 85));
        send_request(make_req(OP_READ, 0, 0, 170));
        send_request(make_req(OP_READ, 0, 0, 85));
        wait_reports_drained();

        // Phase one, no idling on either side. Part way through the receiver holds off
        // for a long stretch while reads keep arriving, which fills the block up.
        run_random_traffic(PHASE_ITEMS / 2);
        hold_request = 1'b1;
        repeat (30) begin
            send_request(make_req(OP_ADD, int'($urandom_range(0, COORD_MAX)),
                                  int'($urandom_range(0, COORD_MAX)), 9));
            send_request(make_req(OP_READ, 0, 0, int'($urandom_range(0, NUM_ENTRIES - 1))));
        end
        run_random_traffic(PHASE_ITEMS / 2);
        wait_reports_drained();

        // Sender idles about half the time.
        send_idle_pct = 53;
        run_random_traffic(PHASE_ITEMS);
        wait_reports_drained();

        // Receiver stalls about half the time.
        send_idle_pct = 0;
        stall_pct     = 53;
        run_random_traffic(PHASE_ITEMS);
        wait_reports_drained();

        // Both sides idle now and then.
        send_idle_pct = 20;
        stall_pct     = 20;
        run_random_traffic(PHASE_ITEMS);
        wait_reports_drained();

        stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (box_model.mismatch_count == 0 && box_model.pending_reports.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
